// ===== src/rlm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and sequencer states of the RMS level meter.
package rlm_pkg;

	// Sample format and buffer limit
	localparam int SAMPLE_W    = 16;
	localparam int MAX_SAMPLES = 4096;
	localparam int CNT_W       = 13;
	localparam int SUM_W       = 2 * SAMPLE_W + CNT_W - 2;

	// Divider: dividend is the doubled square sum
	localparam int DVD_W  = SUM_W + 1;
	localparam int DVSR_W = CNT_W;
	localparam int DCNT_W = $clog2(DVD_W);

	// Square root: Q0.32 mean in, Q0.16 root out
	localparam int RAD_W  = 32;
	localparam int ROOT_W = RAD_W / 2;
	localparam int RCNT_W = $clog2(ROOT_W);
	localparam int RREM_W = ROOT_W + 2;

	// Smoothing weights in Q0.16, summing to one
	localparam int LVL_W = 16;
	localparam logic [15:0] W_OLD = 16'd60948;
	localparam logic [12:0] W_NEW = 13'd4588;
	localparam logic [32:0] ROUND_HALF = 33'd32768;

	// Display scale: level * 384000 / 1114112 = ((level * 375) >> 6) / 17
	localparam logic [8:0]  SCALE_MUL   = 9'd375;
	localparam int          SCALE_SHIFT = 6;
	localparam int          SCL_PROD_W  = LVL_W + 9;
	localparam int          SCL_W       = LVL_W + 9 - SCALE_SHIFT;
	localparam int          SCALED_W    = 12;
	localparam logic [SCALED_W-1:0] SCALE_MAX = 12'd3840;

	// Divide by 17 as a multiply by ceil(2^24 / 17), exact for 19-bit operands
	localparam int                 RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] SCALE_RECIP = 20'd986896;
	localparam int                 RECIP_SHIFT = 24;
	localparam int                 SCQ_W       = SCL_W + RECIP_W - RECIP_SHIFT;

	localparam int TALLY_W = 32;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       is_last;
	} in_item_t;

	typedef struct packed {
		logic [LVL_W-1:0]    smoothed_level;
		logic [SCALED_W-1:0] scaled_level;
		logic [TALLY_W-1:0]  buffers_seen;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MEAN_GO,
		S_MEAN_RUN,
		S_ROOT_GO,
		S_ROOT_RUN,
		S_MUL_OLD,
		S_MUL_NEW,
		S_MUL_SCALE,
		S_SCALE_DIV,
		S_EMIT
	} state_t;

endpackage

// ===== src/rlm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, used for the buffer mean.
module rlm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rlm_pkg::DVD_W-1:0]     dividend,
	input  logic [rlm_pkg::DVSR_W-1:0]    divisor,
	output logic [rlm_pkg::DVD_W-1:0]     quotient,
	output logic                          done
);
	import rlm_pkg::*;

	logic [DVD_W-1:0]  quo_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;

	logic [DVSR_W:0]   rem_sh;
	logic              q_bit;
	logic [DVSR_W-1:0] rem_n;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		rem_sh = {rem_q, quo_q[DVD_W-1]};
		q_bit  = (rem_sh >= {1'b0, dvsr_q});
		rem_n  = q_bit ? DVSR_W'(rem_sh - {1'b0, dvsr_q}) : rem_sh[DVSR_W-1:0];
	end

	assign done     = busy_q && (cnt_q == DCNT_W'(DVD_W - 1));
	assign quotient = quo_q;

	// Control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + DCNT_W'(1);
		end
	end

	// Datapath: shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], q_bit};
			rem_q <= rem_n;
		end
	end

endmodule

// ===== src/rlm_sqrt.sv =====
`timescale 1ns / 1ps
// Digit-by-digit floor square root, one root bit per cycle.
module rlm_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rlm_pkg::RAD_W-1:0]  radicand,
	output logic [rlm_pkg::ROOT_W-1:0] root,
	output logic                       done
);
	import rlm_pkg::*;

	logic [RAD_W-1:0]  rad_q;
	logic [RREM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [RCNT_W-1:0] cnt_q;
	logic              busy_q;

	logic [RREM_W+1:0] rem_sh;
	logic [RREM_W+1:0] trial;
	logic              r_bit;

	// Bring down two radicand bits and try root*4+1
	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		r_bit  = (rem_sh >= trial);
	end

	assign done = busy_q && (cnt_q == RCNT_W'(ROOT_W - 1));
	assign root = root_q;

	// Control: count root bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + RCNT_W'(1);
		end
	end

	// Datapath: advance remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], r_bit};
			rem_q  <= r_bit ? RREM_W'(rem_sh - trial) : RREM_W'(rem_sh);
		end
	end

endmodule

// ===== src/rms_level_meter_smoothed_unit.sv =====
`timescale 1ns / 1ps
// Top level: sample accumulation, buffer-close sequencer and result register.
// An ordinary sample is accepted and accumulated in the same cycle, while the sequencer is idle.
// A sample marked last runs the divider start state, one pass of the bit-serial divider, the root
// start state, the square root, 4 multiply steps and the emit state before its result is registered.
// No input is taken during that sequence, nor while a second result waits for the first.
// Reset (arst_n low, asynchronous) clears sum, count, level, buffer count and valid.
module rms_level_meter_smoothed_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  rlm_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output rlm_pkg::out_item_t result
);
	import rlm_pkg::*;

	state_t state_q, state_n;

	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    count_q;
	logic [LVL_W-1:0]    level_q;
	logic [TALLY_W-1:0]  tally_q;
	logic [31:0]         prod_q;
	logic [LVL_W-1:0]    mix_q;
	logic [SCL_W-1:0]    scl_q;
	logic [SCALED_W-1:0] scaled_q;
	out_item_t           result_q;
	logic                result_valid_q;

	logic [SAMPLE_W-1:0]      raw;
	logic [SAMPLE_W-1:0]      mag;
	logic [2*SAMPLE_W-1:0]    sq;
	logic                     in_fire;
	logic                     emit_fire;
	logic                     div_start;
	logic                     root_start;
	logic [DVD_W-1:0]         div_dividend;
	logic [DVSR_W-1:0]        div_divisor;
	logic [DVD_W-1:0]         div_quo;
	logic                     div_done;
	logic [ROOT_W-1:0]        root;
	logic                     root_done;
	logic [ROOT_W-1:0]        rms;
	logic [28:0]              new_prod;
	logic [32:0]              mix_sum;
	logic [16:0]              mix_lvl;
	logic [SCL_W+RECIP_W-1:0] recip_prod;
	logic [SCQ_W-1:0]         scale_quo;
	logic [SCALED_W-1:0]      scaled;

	// Magnitude of the two's-complement sample
	assign raw     = item.sample;
	assign mag     = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
	assign sq      = mag * mag;
	assign in_fire = item_valid && item_ready;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:      if (in_fire && item.is_last) state_n = S_MEAN_GO;
			S_MEAN_GO:   state_n = S_MEAN_RUN;
			S_MEAN_RUN:  if (div_done) state_n = S_ROOT_GO;
			S_ROOT_GO:   state_n = S_ROOT_RUN;
			S_ROOT_RUN:  if (root_done) state_n = S_MUL_OLD;
			S_MUL_OLD:   state_n = S_MUL_NEW;
			S_MUL_NEW:   state_n = S_MUL_SCALE;
			S_MUL_SCALE: state_n = S_SCALE_DIV;
			S_SCALE_DIV: state_n = S_EMIT;
			S_EMIT:      if (!result_valid_q || result_ready) state_n = S_IDLE;
			default:     state_n = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		item_ready = 1'b0;
		div_start  = 1'b0;
		root_start = 1'b0;
		emit_fire  = 1'b0;
		unique case (state_q)
			S_IDLE:     item_ready = 1'b1;
			S_MEAN_GO:  div_start = 1'b1;
			S_ROOT_GO:  root_start = 1'b1;
			S_EMIT:     emit_fire = !result_valid_q || result_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Divider operands: doubled sum over count
	assign div_dividend = {sum_q, 1'b0};
	assign div_divisor  = count_q;

	rlm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done)
	);

	rlm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (div_quo[RAD_W-1:0]),
		.root     (root),
		.done     (root_done)
	);

	// An empty buffer reads as zero RMS
	assign rms = (count_q == '0) ? '0 : root;

	// Blend old level and new RMS, round half up, saturate
	assign new_prod = 29'(rms) * 29'(W_NEW);
	assign mix_sum  = {1'b0, prod_q} + 33'(new_prod) + ROUND_HALF;
	assign mix_lvl  = mix_sum[32:16];

	// Divide the display scale by 17 through the reciprocal, then clamp
	assign recip_prod = (SCL_W + RECIP_W)'(scl_q) * (SCL_W + RECIP_W)'(SCALE_RECIP);
	assign scale_quo  = recip_prod[SCL_W+RECIP_W-1 -: SCQ_W];
	assign scaled     = (scale_quo > SCQ_W'(SCALE_MAX)) ? SCALE_MAX : scale_quo[SCALED_W-1:0];

	// Accumulate squares and count; drop samples past the buffer limit; clear both when a result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (emit_fire) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (in_fire && (count_q < CNT_W'(MAX_SAMPLES))) begin
			sum_q   <= sum_q + SUM_W'(sq);
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Smoothed level and buffer count advance when a result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			tally_q <= '0;
		end else if (emit_fire) begin
			level_q <= mix_q;
			tally_q <= tally_q + TALLY_W'(1);
		end
	end

	// Multiply steps, one product per cycle
	always_ff @(posedge clk) begin
		if (state_q == S_MUL_OLD) begin
			prod_q <= level_q * W_OLD;
		end
		if (state_q == S_MUL_NEW) begin
			mix_q <= mix_lvl[16] ? '1 : mix_lvl[LVL_W-1:0];
		end
		if (state_q == S_MUL_SCALE) begin
			scl_q <= SCL_W'((SCL_PROD_W'(mix_q) * SCL_PROD_W'(SCALE_MUL)) >> SCALE_SHIFT);
		end
		if (state_q == S_SCALE_DIV) begin
			scaled_q <= scaled;
		end
	end

	// Result register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			result_q.smoothed_level <= mix_q;
			result_q.scaled_level   <= scaled_q;
			result_q.buffers_seen   <= tally_q + TALLY_W'(1);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== src/rlm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the RMS level meter, bound to the top level.
module rlm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input rlm_pkg::in_item_t  item,
	input logic               result_valid,
	input logic               result_ready,
	input rlm_pkg::out_item_t result
);
	import rlm_pkg::*;

	// A waiting result word stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped before it was taken");

	// Closing a buffer stalls the input while the level is worked out
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.is_last |=> !item_ready)
		else $error("input taken while a buffer close is in progress");

	// A new result appears only at the end of a busy stretch
	a_result_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result issued without a buffer close");

	// Display scale never exceeds its clamp
	a_scale_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.scaled_level <= SCALE_MAX))
		else $error("display scale above clamp");

endmodule

bind rms_level_meter_smoothed_unit rlm_checker u_rlm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the RMS level meter: directed table, random buffers, stall pressure.
module tb;
	import rlm_pkg::*;

	// Smoothing constants in Q0.16, then display scale and clamps
	localparam longint unsigned KEEP_WT   = 60948;
	localparam longint unsigned TAKE_WT   = 4588;
	localparam longint unsigned ROUND_Q16 = 32768;
	localparam longint unsigned DISP_NUM  = 384000;
	localparam longint unsigned DISP_DEN  = 1114112;
	localparam longint unsigned DISP_CAP  = 3840;
	localparam longint unsigned ROOT_CAP  = 65535;
	localparam int MEAN_SHIFT = 32 - 2 * (SAMPLE_W - 1);

	localparam int RAND_ITEMS = 2000;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD  = 600;
	localparam int HOLD_AT    = 30;
	localparam int PAUSE_AT   = 60;
	localparam int DRAIN_WAIT = 150;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
		logic                pinned;
		out_item_t           pin;
	} dir_row_t;

	localparam int N_DIR = 18;
	localparam out_item_t NO_PIN = '0;

	// Directed stimulus; pinned rows carry the level that follows directly from reset
	localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
		'{16'h0000, 1'b1, 1'b1, '{16'd0, 12'd0, 32'd1}},
		'{16'h0000, 1'b0, 1'b0, NO_PIN},
		'{16'h0000, 1'b1, 1'b1, '{16'd0, 12'd0, 32'd2}},
		'{16'h8000, 1'b1, 1'b0, NO_PIN},
		'{16'h7FFF, 1'b1, 1'b0, NO_PIN},
		'{16'h8000, 1'b1, 1'b0, NO_PIN},
		'{16'h8000, 1'b1, 1'b0, NO_PIN},
		'{16'h7FFF, 1'b1, 1'b0, NO_PIN},
		'{16'h0001, 1'b0, 1'b0, NO_PIN},
		'{16'hFFFF, 1'b0, 1'b0, NO_PIN},
		'{16'h5555, 1'b0, 1'b0, NO_PIN},
		'{16'hAAAA, 1'b0, 1'b0, NO_PIN},
		'{16'h4000, 1'b0, 1'b0, NO_PIN},
		'{16'hC000, 1'b1, 1'b0, NO_PIN},
		'{16'h0000, 1'b1, 1'b0, NO_PIN},
		'{16'h0000, 1'b1, 1'b0, NO_PIN},
		'{16'hFFFF, 1'b1, 1'b0, NO_PIN},
		'{16'h0001, 1'b1, 1'b0, NO_PIN}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	// Predictor state
	longint unsigned sq_acc = 0;
	int              n_acc = 0;
	longint unsigned level_reg = 0;
	logic [31:0]     tally_reg = '0;

	out_item_t level_q [$];
	int  mismatch_cnt = 0;
	int  results_seen = 0;
	int  samples_sent = 0;
	int  buffers_sent = 0;
	int  idle_cycles = 0;
	bit  sender_calm = 1'b0;
	bit  rcv_calm = 1'b0;

	rms_level_meter_smoothed_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int gap_draw(bit calm);
		return calm ? 0 : int'($urandom_range(0, 12));
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			b = r | (64'd1 << i);
			if (b * b <= v)
				r = b;
		end
		return r;
	endfunction

	// Accumulate one sample; on a closing word, compute the smoothed level
	task automatic level_predict(input in_item_t w, output bit closed, output out_item_t o);
		longint unsigned mag;
		longint unsigned mean;
		longint unsigned root;
		longint unsigned lvl;
		longint unsigned scl;
		o = '0;
		mag = w.sample[SAMPLE_W-1] ? 64'({1'b0, ~w.sample}) + 64'd1 : 64'({1'b0, w.sample});
		// drop samples past the buffer limit
		if (n_acc < MAX_SAMPLES) begin
			sq_acc = sq_acc + mag * mag;
			n_acc = n_acc + 1;
		end
		closed = w.is_last;
		if (!closed)
			return;
		mean = 0;
		root = 0;
		if (n_acc != 0) begin
			mean = (sq_acc << MEAN_SHIFT) / 64'(2 * n_acc);
			root = floor_root(mean);
			if (root > ROOT_CAP)
				root = ROOT_CAP;
		end
		lvl = (level_reg * KEEP_WT + root * TAKE_WT + ROUND_Q16) >> 16;
		if (lvl > ROOT_CAP)
			lvl = ROOT_CAP;
		level_reg = lvl;
		scl = lvl * DISP_NUM / DISP_DEN;
		if (scl > DISP_CAP)
			scl = DISP_CAP;
		tally_reg = tally_reg + 32'd1;
		sq_acc = 0;
		n_acc = 0;
		o.smoothed_level = lvl[LVL_W-1:0];
		o.scaled_level   = scl[SCALED_W-1:0];
		o.buffers_seen   = tally_reg;
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	// Offer one word after a random gap, hold it until taken, then predict
	task automatic send_word(input in_item_t w, input bit pinned, input out_item_t pin);
		int gap;
		bit closed;
		out_item_t o;
		gap = gap_draw(sender_calm);
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		samples_sent++;
		level_predict(w, closed, o);
		if (closed) begin
			buffers_sent++;
			level_q = {level_q, (pinned ? pin : o)};
		end
	endtask

	task automatic sender_hold();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// Count cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Result side: random stalls, one long hold-off, field-by-field check
	initial begin
		out_item_t want;
		int n;
		bit hold_done;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rcv_calm = ~rcv_calm;
			n = gap_draw(rcv_calm);
			if (!hold_done && results_seen == HOLD_AT) begin
				n = LONG_HOLD;
				hold_done = 1'b1;
			end
			repeat (n) begin
				@(negedge clk);
				result_ready <= 1'b0;
			end
			@(negedge clk);
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			results_seen++;
			if (level_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
			end else begin
				want = level_q.pop_front();
				if (result.smoothed_level !== want.smoothed_level)
					report_mismatch($sformatf("result %0d smoothed_level got %0d expected %0d",
						results_seen, result.smoothed_level, want.smoothed_level));
				if (result.scaled_level !== want.scaled_level)
					report_mismatch($sformatf("result %0d scaled_level got %0d expected %0d",
						results_seen, result.scaled_level, want.scaled_level));
				if (result.buffers_seen !== want.buffers_seen)
					report_mismatch($sformatf("result %0d buffers_seen got %0d expected %0d",
						results_seen, result.buffers_seen, want.buffers_seen));
			end
		end
	end

	// Stimulus: reset, directed table, random buffers, drain
	initial begin
		in_item_t w;
		int plain_items;
		int buf_idx;
		int len;
		int amp;
		int s;
		plain_items = 0;
		buf_idx = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		for (int r = 0; r < N_DIR; r++) begin
			w.sample  = DIR_TAB[r].sample;
			w.is_last = DIR_TAB[r].last;
			send_word(w, DIR_TAB[r].pinned, DIR_TAB[r].pin);
		end

		// random buffers of mixed length and amplitude
		while (plain_items < RAND_ITEMS) begin
			buf_idx++;
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(1, 3);
			else
				len = $urandom_range(1, 24);
			case ($urandom_range(0, 4))
				0: amp = 8;
				1: amp = 1024;
				2: amp = 16384;
				default: amp = 32768;
			endcase
			if ($urandom_range(0, 5) == 0)
				sender_calm = ~sender_calm;
			for (int k = 0; k < len; k++) begin
				s = int'($urandom_range(0, 2 * amp - 1)) - amp;
				w.sample  = s[SAMPLE_W-1:0];
				w.is_last = (k == len - 1);
				send_word(w, 1'b0, NO_PIN);
			end
			plain_items += len;
			// let the block drain completely once
			if (buf_idx == PAUSE_AT) begin
				sender_hold();
				while (level_q.size() != 0)
					@(negedge clk);
			end
		end

		sender_hold();
		while (level_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d samples in %0d buffers; %0d results checked.",
			samples_sent, buffers_sent, results_seen);
		$display("Included full-scale extremes, display clamp, short buffers and a long stall.");
		if (mismatch_cnt == 0 && level_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/rlm_pkg.sv
src/rlm_div.sv
src/rlm_sqrt.sv
src/rms_level_meter_smoothed_unit.sv
src/rlm_checker.sv
tb/tb.sv
